// ----- rtl/core/aes_bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// AES block cipher package
// Shared types, constants and GF(2^8) byte functions.
// ----------------------------------------------------------------------------
package aes_bcc_pkg;

  localparam int unsigned MaxKeyWordsDef = 8;
  localparam int unsigned RkDepth        = 60;
  localparam int unsigned RkAddrW        = 6;
  localparam int unsigned CfgAddrW       = 6;
  localparam logic [3:0]  NibbleMask     = 4'hF;

  localparam logic [CfgAddrW-1:0] AddrKeyWords = 6'd0;
  localparam logic [CfgAddrW-1:0] AddrKey0     = 6'd8;
  localparam logic [CfgAddrW-1:0] AddrKey1     = 6'd16;
  localparam logic [CfgAddrW-1:0] AddrKey2     = 6'd24;
  localparam logic [CfgAddrW-1:0] AddrKey3     = 6'd32;

  typedef enum logic [0:0] {
    ReqEncrypt = 1'b0,
    ReqDecrypt = 1'b1
  } req_type_e;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = xtime(x);
    end
    gmul = r;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h01;
    for (int bit_i = 7; bit_i >= 0; bit_i--) begin
      r = gmul(r, r);
      if (bit_i != 0) r = gmul(r, a);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int unsigned n);
    rotl8 = (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sbox_calc(input logic [7:0] x);
    inv_sbox_calc = ginv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_t [256];

  function automatic sbox_t make_sbox(input logic inverse);
    sbox_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inverse ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    make_sbox = t;
  endfunction

  localparam sbox_t Sbox    = make_sbox(1'b0);
  localparam sbox_t InvSbox = make_sbox(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  typedef struct packed {
    logic       start;
    logic [3:0] nk;
  } kexp_ctrl_t;

endpackage

// ----- rtl/core/aes_bcc_if.sv -----
// ----------------------------------------------------------------------------
// AES item channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface aes_bcc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  logic [63:0] chain_hi;
  logic [63:0] chain_lo;
  modport source (output valid, req_type, block_hi, block_lo, chain_hi, chain_lo,
                  input ready);
  modport sink   (input valid, req_type, block_hi, block_lo, chain_hi, chain_lo,
                  output ready);
endinterface

interface aes_bcc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  modport source (output valid, result_hi, result_lo, input ready);
  modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

// ----- rtl/core/aes_block_cipher_with_chaining_unit.sv -----
// ----------------------------------------------------------------------------
// AES block cipher with chaining
// AES-128/192/256 with pre-XOR (encrypt) or post-XOR (decrypt) chaining.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// req      | in  | req_type, block_hi, block_lo, chain_hi, chain_lo
// rsp      | out | result_hi, result_lo
// apb      | in  | key_words @0x00, key_0..key_3 @0x08..0x20, 64-bit data
//
// An item runs Nr+1 rounds from accept to result: per round, StFetch and
// StRound read the round key as four words from one port, then StDone
// applies it through the shared round unit.
// After a key write the first item first runs the schedule before it is
// taken. The result register waits for the sink; no new item meanwhile,
// and the next item is taken only after the result has been accepted.
// ----------------------------------------------------------------------------
module aes_block_cipher_with_chaining_unit #(
  parameter int unsigned MaxKeyWords = aes_bcc_pkg::MaxKeyWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aes_bcc_req_if.sink   req,
  aes_bcc_rsp_if.source rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [aes_bcc_pkg::CfgAddrW-1:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import aes_bcc_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StKexp  = 6'b000010,
    StFetch = 6'b000100,
    StRound = 6'b001000,
    StDone  = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  state_e       st_q, st_d;
  logic [3:0]   key_words_q;
  logic [63:0]  key_q [4];
  logic         keys_ready_q, keys_ready_d;
  logic         dec_q, dec_d;
  logic [127:0] state_q, state_d;
  logic [127:0] chain_q, chain_d;
  logic [127:0] rk_q, rk_d;
  logic [127:0] res_q, res_d;
  logic [3:0]   nk, nr_q, nr_d;
  logic [3:0]   rnd_q, rnd_d;
  logic [1:0]   wsel_q, wsel_d;
  logic         cfg_we;
  logic [31:0]  rk_mem [RkDepth];
  logic [31:0]  rk_rdata;
  logic [5:0]   raddr;
  logic [127:0] round_out;
  logic         kx_busy, kx_we;
  logic [5:0]   kx_waddr;
  logic [31:0]  kx_wdata;
  kexp_ctrl_t   kx_ctrl;
  logic [3:0]   kw_clip;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (paddr)
      AddrKeyWords: prdata = {60'h0, key_words_q};
      AddrKey0:     prdata = key_q[0];
      AddrKey1:     prdata = key_q[1];
      AddrKey2:     prdata = key_q[2];
      AddrKey3:     prdata = key_q[3];
      default:      prdata = 64'h0;
    endcase
  end

  always_comb begin
    kw_clip = key_words_q & NibbleMask;
    if (kw_clip < 4'd4) kw_clip = 4'd4;
    if (kw_clip > 4'(MaxKeyWords)) kw_clip = 4'(MaxKeyWords);
    nk = {kw_clip[3:1], 1'b0};
  end

  assign kx_ctrl.start = (st_q == StIdle) && req.valid && !keys_ready_q;
  assign kx_ctrl.nk    = nk;

  aes_bcc_kexp u_kexp (
    .clk_i, .rst_ni,
    .ctrl_i  (kx_ctrl),
    .key_i   ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .busy_o  (kx_busy),
    .we_o    (kx_we),
    .waddr_o (kx_waddr),
    .wdata_o (kx_wdata)
  );

  always_ff @(posedge clk_i) begin
    if (kx_we) rk_mem[kx_waddr] <= kx_wdata;
    rk_rdata <= rk_mem[raddr];
  end

  aes_bcc_round u_round (
    .inverse_i (dec_q),
    .last_i    (rnd_q == nr_q),
    .state_i   (state_q),
    .rkey_i    (rk_q),
    .state_o   (round_out)
  );

  // Word address for the next fetch: key of round rnd_d (round nr_d - rnd_d when decrypting), word wsel_d.
  logic [3:0] frnd;
  always_comb begin
    frnd  = dec_d ? 4'(nr_d - rnd_d) : rnd_d;
    raddr = 6'({2'b00, frnd} * 4 + {4'b0, wsel_d});
  end

  always_comb begin
    st_d = st_q; keys_ready_d = keys_ready_q; dec_d = dec_q;
    state_d = state_q; chain_d = chain_q; rk_d = rk_q; res_d = res_q;
    nr_d = nr_q; rnd_d = rnd_q; wsel_d = wsel_q;
    req.ready = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (req.valid) begin
          if (!keys_ready_q) begin
            st_d = StKexp;
          end else begin
            req.ready = 1'b1;
            dec_d   = req.req_type;
            chain_d = {req.chain_hi, req.chain_lo};
            state_d = {req.block_hi, req.block_lo} ^
                      (req.req_type == ReqEncrypt ? {req.chain_hi, req.chain_lo} : 128'h0);
            nr_d   = nk + 4'd6;
            rnd_d  = 4'd0;
            wsel_d = 2'd0;
            st_d   = StFetch;
          end
        end
      end
      StKexp: begin
        if (!kx_busy) begin
          keys_ready_d = 1'b1;
          st_d = StIdle;
        end
      end
      StFetch: begin
        // Read data is registered, so it arrives in the cycle after its address; collect the four words.
        rk_d   = {rk_q[95:0], rk_rdata};
        wsel_d = 2'd1;
        st_d   = StRound;
      end
      StRound: begin
        rk_d = {rk_q[95:0], rk_rdata};
        if (wsel_q == 2'd3) begin
          st_d = StDone;
        end else begin
          wsel_d = wsel_q + 2'd1;
        end
      end
      StDone: begin
        if (rnd_q == 4'd0) state_d = state_q ^ rk_q;
        else               state_d = round_out;
        if (rnd_q == nr_q) begin
          res_d = (dec_q ? chain_q : 128'h0) ^ round_out;
          st_d  = StOut;
        end else begin
          rnd_d  = rnd_q + 4'd1;
          wsel_d = 2'd0;
          st_d   = StFetch;
        end
      end
      StOut: begin
        if (rsp.ready) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
    if (cfg_we && (paddr == AddrKeyWords || paddr == AddrKey0 || paddr == AddrKey1 ||
                   paddr == AddrKey2 || paddr == AddrKey3))
      keys_ready_d = 1'b0;
  end

  assign rsp.valid     = (st_q == StOut);
  assign rsp.result_hi = res_q[127:64];
  assign rsp.result_lo = res_q[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= StIdle;
      keys_ready_q <= 1'b0;
      key_words_q  <= 4'd4;
      for (int i = 0; i < 4; i++) key_q[i] <= 64'h0;
    end else begin
      st_q         <= st_d;
      keys_ready_q <= keys_ready_d;
      if (cfg_we) begin
        unique case (paddr)
          AddrKeyWords: key_words_q <= pwdata[3:0];
          AddrKey0:     key_q[0] <= pwdata;
          AddrKey1:     key_q[1] <= pwdata;
          AddrKey2:     key_q[2] <= pwdata;
          AddrKey3:     key_q[3] <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q <= dec_d; state_q <= state_d; chain_q <= chain_d; rk_q <= rk_d;
    res_q <= res_d; nr_q <= nr_d; rnd_q <= rnd_d; wsel_q <= wsel_d;
  end
endmodule

// ----- rtl/core/aes_bcc_round.sv -----
// ----------------------------------------------------------------------------
// AES round unit
// One forward or inverse round on a 128-bit state, combinational.
// ----------------------------------------------------------------------------
module aes_bcc_round (
  input  logic         inverse_i,
  input  logic         last_i,
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  output logic [127:0] state_o
);
  import aes_bcc_pkg::*;

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] u [16];
  logic [7:0] m [16];

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = state_i[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse_i) t[c*4+r] = InvSbox[s[((c - r + 4) & 3)*4 + r]];
        else           t[c*4+r] = Sbox[s[((c + r) & 3)*4 + r]];
      end
    end
    // Inverse round adds the key before the column mix.
    for (int i = 0; i < 16; i++) u[i] = inverse_i ? (t[i] ^ rkey_i[127-8*i -: 8]) : t[i];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse_i)
          m[c*4+r] = gmul(8'd14, u[c*4+r]) ^ gmul(8'd11, u[c*4+((r+1)&3)]) ^
                     gmul(8'd13, u[c*4+((r+2)&3)]) ^ gmul(8'd9, u[c*4+((r+3)&3)]);
        else
          m[c*4+r] = xtime(u[c*4+r]) ^ xtime(u[c*4+((r+1)&3)]) ^ u[c*4+((r+1)&3)] ^
                     u[c*4+((r+2)&3)] ^ u[c*4+((r+3)&3)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (last_i)         state_o[127-8*i -: 8] = t[i] ^ rkey_i[127-8*i -: 8];
      else if (inverse_i) state_o[127-8*i -: 8] = m[i];
      else                state_o[127-8*i -: 8] = m[i] ^ rkey_i[127-8*i -: 8];
    end
  end
endmodule

// ----- rtl/core/aes_bcc_kexp.sv -----
// ----------------------------------------------------------------------------
// AES key expansion
// Writes one round key word a cycle into the key memory shared with the cipher.
// ----------------------------------------------------------------------------
module aes_bcc_kexp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  aes_bcc_pkg::kexp_ctrl_t ctrl_i,
  input  logic [255:0]            key_i,
  output logic                    busy_o,
  output logic                    we_o,
  output logic [5:0]              waddr_o,
  output logic [31:0]             wdata_o
);
  import aes_bcc_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  idx_q, idx_d;
  logic [5:0]  total_q, total_d;
  logic [3:0]  nk_q, nk_d;
  logic [3:0]  mod_q, mod_d;
  logic [7:0]  rcon_q, rcon_d;
  logic [31:0] win [8];
  logic [31:0] win_d [8];
  logic [31:0] t;
  logic [31:0] nw;

  always_comb begin
    t = win[nk_q[2:0] - 3'd1];
    if (mod_q == 4'd0)
      t = sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'h0};
    else if (nk_q == 4'd8 && mod_q == 4'd4)
      t = sub_word(t);
    nw = win[0] ^ t;
  end

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    total_d = total_q;
    nk_d    = nk_q;
    mod_d   = mod_q;
    rcon_d  = rcon_q;
    for (int i = 0; i < 8; i++) win_d[i] = win[i];
    we_o    = 1'b0;
    waddr_o = idx_q;
    wdata_o = nw;
    if (ctrl_i.start) begin
      busy_d  = 1'b1;
      idx_d   = 6'd0;
      nk_d    = ctrl_i.nk;
      total_d = 6'((ctrl_i.nk + 4'd7) * 4);
      mod_d   = 4'd0;
      rcon_d  = 8'h01;
      for (int i = 0; i < 8; i++) win_d[i] = key_i[255-32*i -: 32];
    end else if (busy_q) begin
      we_o = 1'b1;
      if (idx_q < 6'(nk_q)) begin
        // Key words go straight out; the window still holds the key.
        wdata_o = win[idx_q[2:0]];
      end else begin
        for (int i = 0; i < 7; i++) win_d[i] = win[i+1];
        win_d[nk_q[2:0] - 3'd1] = nw;
        mod_d = (mod_q == nk_q - 4'd1) ? 4'd0 : mod_q + 4'd1;
        if (mod_q == 4'd0) rcon_d = xtime(rcon_q);
      end
      idx_d = idx_q + 6'd1;
      if (idx_q + 6'd1 == total_q) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    total_q <= total_d;
    nk_q    <= nk_d;
    mod_q   <= mod_d;
    rcon_q  <= rcon_d;
    for (int i = 0; i < 8; i++) win[i] <= win_d[i];
  end

  assign busy_o = busy_q;
endmodule
